@@ rtl/core/qifc_pkg.sv @@
package qifc_pkg;

  localparam int MaxFields = 16;
  localparam int FracBits = 16;
  localparam int CntW = $clog2(MaxFields + 1);

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegGain = 2'd1;
  localparam logic [1:0] RegOffset = 2'd2;

  localparam logic [1:0] ModeProduct = 2'd0;
  localparam logic [1:0] ModeMean = 2'd1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusSat = 2'd1;
  localparam logic [1:0] StatusOver = 2'd2;

  typedef struct packed {
    logic signed [31:0] raw_value;
    logic signed [31:0] field_gain;
    logic signed [31:0] field_offset;
    logic               last_field;
  } word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_COMBINE,
    ST_ACCUM,
    ST_APPLY,
    ST_FINISH,
    ST_MEAN,
    ST_DIV,
    ST_OUT
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v, output logic sat);
    sat = 1'b0;
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      sat32 = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      sat = 1'b1;
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/core/quality_index_field_combiner_top.sv @@
// Quality index combiner. Takes one word per field, pixel interleaved, and emits one
// result on each word flagged last_field. A two-word queue decouples input from the
// arithmetic. A field that opens a pixel or is past the field limit passes accept,
// scale multiply and scale and saturate; one combined by sum or minimum adds accumulate,
// and one combined by product adds accumulate and product saturate. The end of a pixel
// runs a 64-step shift-subtract division (twice in mean mode, which divides twice) before
// the result is offered, and the result is held until taken. Configure only while idle.
module quality_index_field_combiner_top
  import qifc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] raw_value,
  input  logic signed [31:0] field_gain,
  input  logic signed [31:0] field_offset,
  input  logic               last_field,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] quality,
  output logic [4:0]         field_count,
  output logic [1:0]         status
);

  logic [1:0]         combine_mode;
  logic signed [31:0] out_gain;
  logic signed [31:0] out_offset;
  word_t              in_word;
  word_t              q_word;
  logic               q_valid;
  logic               q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= ModeProduct;
      out_gain <= 32'sd1 <<< FracBits;
      out_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMode: combine_mode <= cfg_data[1:0];
        RegGain: if (cfg_data != '0) out_gain <= cfg_data;
        RegOffset: out_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_word = '{raw_value, field_gain, field_offset, last_field};

  qifc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_word  (q_word)
  );

  qifc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_word      (q_word),
    .combine_mode (combine_mode),
    .out_gain     (out_gain),
    .out_offset   (out_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .quality      (quality),
    .field_count  (field_count),
    .status       (status)
  );

endmodule

@@ rtl/core/qifc_queue.sv @@
module qifc_queue
  import qifc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t in_word,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_word
);

  word_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic push;
  logic pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_word;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/qifc_divider.sv @@
module qifc_divider
  import qifc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  logic [63:0] num;
  logic [63:0] rem;
  logic [31:0] den;
  logic        neg;
  logic [6:0]  step;
  logic        busy;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem[62:0], num[63]};
  assign trial = {1'b0, rem_sh} - {33'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 7'd0;
        num <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        den <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        neg <= dividend[63] ^ divisor[31];
        rem <= 64'd0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          num <= {num[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          num <= {num[62:0], 1'b0};
        end
        step <= step + 7'd1;
        if (step == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 64'(-num) : 64'(num);

endmodule

@@ rtl/core/qifc_back.sv @@
module qifc_back
  import qifc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  word_t                  in_word,
  input  logic [1:0]             combine_mode,
  input  logic signed [31:0]     out_gain,
  input  logic signed [31:0]     out_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     quality,
  output logic [4:0]             field_count,
  output logic [1:0]             status
);

  back_state_t state, state_next;

  logic signed [31:0] acc;
  logic [CntW-1:0]    seen;
  logic               sat_flag;
  logic               over_flag;
  word_t              cur;
  logic signed [63:0] prod;
  logic signed [31:0] sval;
  logic               div_start;
  logic signed [63:0] div_a;
  logic signed [31:0] div_b;
  logic               div_done;
  logic signed [63:0] div_q;
  logic               mean_pass;

  logic signed [63:0] mul_a;
  logic signed [63:0] mul_full;
  logic signed [65:0] sc_sum;
  logic signed [31:0] sc_sat;
  logic               sc_s;
  logic signed [31:0] cb_sat;
  logic               cb_s;
  logic signed [31:0] q_sat;
  logic               q_s;
  logic signed [65:0] add_sum;

  assign mul_full = 64'(cur.raw_value) * 64'(cur.field_gain);
  assign mul_a = 64'(sval) * 64'(acc);
  assign sc_sum = 66'(prod >>> FracBits) + 66'(cur.field_offset);
  assign add_sum = 66'(acc) + 66'(sval);

  always_comb begin
    sc_sat = sat32(sc_sum, sc_s);
    if (combine_mode == ModeProduct) cb_sat = sat32(66'(prod >>> FracBits), cb_s);
    else cb_sat = sat32(add_sum, cb_s);
    q_sat = sat32(66'(div_q), q_s);
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_a = 64'sd0;
    div_b = out_gain;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_COMBINE;
      ST_COMBINE: begin
        if (seen >= CntW'(MaxFields) || seen == '0) begin
          state_next = cur.last_field ? ST_FINISH : ST_IDLE;
        end else begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (combine_mode == ModeProduct) state_next = ST_APPLY;
        else state_next = cur.last_field ? ST_FINISH : ST_IDLE;
      end
      ST_APPLY: state_next = cur.last_field ? ST_FINISH : ST_IDLE;
      ST_FINISH: begin
        div_start = 1'b1;
        if (combine_mode == ModeMean && seen != '0) begin
          div_a = 64'(acc);
          div_b = 32'(seen);
        end else begin
          div_a = (64'(acc) - 64'(out_offset)) <<< FracBits;
        end
        state_next = ST_DIV;
      end
      ST_DIV: if (div_done) state_next = mean_pass ? ST_MEAN : ST_OUT;
      ST_MEAN: begin
        div_start = 1'b1;
        div_a = (div_q - 64'(out_offset)) <<< FracBits;
        state_next = ST_DIV;
      end
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid) begin
        cur <= in_word;
      end
      ST_SCALE: prod <= mul_full;
      ST_ACCUM: if (combine_mode == ModeProduct) prod <= mul_a;
      default: ;
    endcase
    if (state == ST_COMBINE) sval <= sc_sat;
    if (rst) begin
      state <= ST_IDLE;
      acc <= '0;
      seen <= '0;
      sat_flag <= 1'b0;
      over_flag <= 1'b0;
      mean_pass <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_COMBINE) begin
        if (seen >= CntW'(MaxFields)) begin
          over_flag <= 1'b1;
        end else begin
          seen <= seen + 1'b1;
          sat_flag <= sat_flag | sc_s;
          if (seen == '0) acc <= sc_sat;
        end
      end
      if (state == ST_ACCUM) begin
        if (combine_mode == ModeMean) begin
          acc <= cb_sat;
          sat_flag <= sat_flag | cb_s;
        end else if (combine_mode != ModeProduct && sval < acc) begin
          acc <= sval;
        end
      end
      if (state == ST_APPLY) begin
        acc <= cb_sat;
        sat_flag <= sat_flag | cb_s;
      end
      if (state == ST_FINISH) mean_pass <= (combine_mode == ModeMean && seen != '0);
      if (state == ST_MEAN) mean_pass <= 1'b0;
      if (state == ST_DIV && div_done && !mean_pass) begin
        quality <= q_sat;
        field_count <= 5'(seen);
        status <= (over_flag) ? StatusOver : ((sat_flag | q_s) ? StatusSat : StatusOk);
      end
      if (state == ST_OUT && out_ready) begin
        acc <= '0;
        seen <= '0;
        sat_flag <= 1'b0;
        over_flag <= 1'b0;
      end
    end
  end

  assign out_valid = (state == ST_OUT);

  qifc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
